// ===== rtl/masked_byte_pattern_scanner_core_assert.svh =====
// ----------------------------------------------------------------------------
// Masked byte pattern scanner assertion macros
// Concurrent assertion wrappers, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH

`ifndef SYNTH

`define MBPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define MBPS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define MBPS_ASSERT(name, prop, msg)

`define MBPS_ASSERT_NEVER(name, cond, msg)

`endif

`endif

// ===== rtl/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned PATTERN_BYTES  = 16;
  localparam int unsigned PATTERN_LEN_W  = 5;
  localparam int unsigned MATCH_OFFSET_W = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LOW  = 2'd0,
    CFG_PATTERN_HIGH = 2'd1,
    CFG_CARE_BITS    = 2'd2,
    CFG_PATTERN_LEN  = 2'd3
  } cfg_idx_e;

  localparam logic [PATTERN_BYTES-1:0] CARE_RESET = '1;
  localparam logic [PATTERN_LEN_W-1:0] LEN_RESET  = 5'd1;

  typedef struct packed {
    logic [PATTERN_BYTES-1:0][7:0]  pattern;
    logic [PATTERN_BYTES-1:0]       care;
    logic [PATTERN_LEN_W-1:0]       length;
  } cfg_t;

endpackage

// ===== rtl/mbps_cfg.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern scanner configuration registers
// Holds pattern bytes, care mask and pattern length written over the cfg port.
// ----------------------------------------------------------------------------
module mbps_cfg
  import mbps_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PATTERN_LOW:  cfg_d.pattern[7:0]  = cfg_data_i;
        CFG_PATTERN_HIGH: cfg_d.pattern[15:8] = cfg_data_i;
        CFG_CARE_BITS:    cfg_d.care   = cfg_data_i[PATTERN_BYTES-1:0];
        CFG_PATTERN_LEN:  cfg_d.length = cfg_data_i[PATTERN_LEN_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern <= '0;
      cfg_q.care    <= CARE_RESET;
      cfg_q.length  <= LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/mbps_scan.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern scanner datapath
// Input register, byte window, masked window compare and result register.
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_scanner_core_assert.svh"

module mbps_scan
  import mbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_of_region_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      found_o,
  output logic [MATCH_OFFSET_W-1:0] match_offset_o
);

  localparam int unsigned LenClog = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned LenW    = (LenClog > PATTERN_LEN_W) ? LenClog : PATTERN_LEN_W;

  // input stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       in_accept, s1_adv;

  // search state
  logic [MAX_PATTERN_BYTES-1:0][7:0] win_q, win_d;
  logic [OFFSET_BITS-1:0]            seen_q, seen_d, seen_inc;
  logic                              reported_q, reported_d;

  // result stage
  logic                      out_valid_q, out_valid_d;
  logic                      found_q;
  logic [MATCH_OFFSET_W-1:0] offset_q;

  logic [LenW-1:0]              len_ext, eff_len;
  logic [MAX_PATTERN_BYTES-1:0] pos_ok;
  logic                         hit, res_valid;
  logic [OFFSET_BITS-1:0]       off_full;
  logic [MATCH_OFFSET_W-1:0]    off_sat;

  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign s1_valid_d = in_accept | (s1_valid_q & ~s1_adv);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_of_region_i;
    end
  end

  // length 0 acts as 1, longer than the window acts as the window
  assign len_ext = LenW'(cfg_i.length);
  always_comb begin
    if (len_ext == '0) begin
      eff_len = LenW'(1);
    end else if (len_ext > LenW'(MAX_PATTERN_BYTES)) begin
      eff_len = LenW'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = len_ext;
    end
  end

  // window after the new word: slot 0 is the newest byte
  always_comb begin
    win_d[0] = s1_byte_q;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      win_d[j] = win_q[j-1];
    end
  end

  // window slot j lines up with pattern byte eff_len-1-j
  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_pos
    logic [LenW-1:0] idx;
    logic            in_use, care;
    assign idx    = eff_len - LenW'(j) - LenW'(1);
    assign in_use = LenW'(j) < eff_len;
    assign care   = in_use && (idx < LenW'(PATTERN_BYTES)) && cfg_i.care[idx[3:0]];
    assign pos_ok[j] = ~care | (win_d[j] == cfg_i.pattern[idx[3:0]]);
  end

  assign seen_inc = (seen_q != '1) ? seen_q + OFFSET_BITS'(1) : seen_q;
  assign hit      = ~reported_q & (seen_inc >= OFFSET_BITS'(eff_len)) & (&pos_ok);
  assign res_valid = hit | (s1_last_q & ~reported_q);
  assign off_full = seen_inc - OFFSET_BITS'(eff_len);

  if (OFFSET_BITS > MATCH_OFFSET_W) begin : g_sat
    assign off_sat = (|off_full[OFFSET_BITS-1:MATCH_OFFSET_W]) ? '1
                                                               : off_full[MATCH_OFFSET_W-1:0];
  end else begin : g_nosat
    assign off_sat = MATCH_OFFSET_W'(off_full);
  end

  always_comb begin
    seen_d     = seen_q;
    reported_d = reported_q;
    if (s1_adv) begin
      if (s1_last_q) begin
        seen_d     = '0;
        reported_d = 1'b0;
      end else begin
        seen_d     = seen_inc;
        reported_d = reported_q | hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    if (s1_adv) begin
      out_valid_d = res_valid;
    end else begin
      out_valid_d = out_valid_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      found_q  <= hit;
      offset_q <= hit ? off_sat : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      seen_q      <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      seen_q      <= seen_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

  `MBPS_ASSERT(a_notfound_zero, out_valid_q && !found_q |-> offset_q == '0, "not-found word with nonzero offset")
  `MBPS_ASSERT(a_one_per_region, s1_adv && reported_q |=> !out_valid_q, "second result in one region")
  `MBPS_ASSERT(a_region_clear, s1_adv && s1_last_q |=> seen_q == '0 && !reported_q, "search state not cleared at region end")
  `MBPS_ASSERT(a_seen_grows, s1_adv && !s1_last_q |=> seen_q >= $past(seen_q), "byte count went backward")
  `MBPS_ASSERT_NEVER(a_stall_idle, in_stall_o && !s1_valid_q, "input stalled with empty input stage")

endmodule

// ===== rtl/masked_byte_pattern_scanner_core.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Finds the first masked pattern match in a byte stream, one region at a time.
// ----------------------------------------------------------------------------
// Takes one byte of a region per clock while the output is not stalled and
// reports, once per region, either the offset of the first byte of the first
// window matching the pattern (wildcards where care_bits is clear) or not
// found at the region's last byte. A word passes through the input register,
// then the result register; the full window compare is combinational, so one
// word is accepted every cycle while the output is not stalled.
// Configure only while no word is in flight.
module masked_byte_pattern_scanner_core
  import mbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_of_region_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      found_o,
  output logic [MATCH_OFFSET_W-1:0] match_offset_o
);

  cfg_t cfg;

  mbps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbps_scan #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_of_region_i (last_of_region_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .found_o          (found_o),
    .match_offset_o   (match_offset_o)
  );

endmodule
